// File: rtl/core/gae_pkg.sv
// gae_pkg: shared constants and codes of the assignment evaluator
// used by gae_tab_ram and gap_assignment_evaluator_core, no dependencies
package gae_pkg;

    localparam int DEF_MAX_AGENTS = 16;
    localparam int DEF_MAX_TASKS  = 64;

    localparam int WGT_W = 31;
    localparam int VAL_W = 32;
    localparam int SUM_W = 40;
    localparam int CFG_W = 7;

    localparam logic [2:0] MODE_LOAD     = 3'd0;
    localparam logic [2:0] MODE_BUDGET   = 3'd1;
    localparam logic [2:0] MODE_SET      = 3'd2;
    localparam logic [2:0] MODE_EVAL     = 3'd3;
    localparam logic [2:0] MODE_REASSIGN = 3'd4;
    localparam logic [2:0] MODE_REPAIR   = 3'd5;

    localparam logic [1:0] CFG_AGENTS = 2'd0;
    localparam logic [1:0] CFG_TASKS  = 2'd1;

endpackage

// File: rtl/core/gae_tab_ram.sv
// gae_tab_ram: task-by-agent weight and value table, one write and one read port
// depends on gae_pkg
module gae_tab_ram #(
    parameter int AW = 4,
    parameter int TW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [TW+AW-1:0]           i_waddr,
    input  logic [gae_pkg::WGT_W-1:0]  i_wdata_w,
    input  logic [gae_pkg::VAL_W-1:0]  i_wdata_v,
    input  logic [TW+AW-1:0]           i_raddr,
    output logic [gae_pkg::WGT_W-1:0]  o_q_w,
    output logic [gae_pkg::VAL_W-1:0]  o_q_v
);
    import gae_pkg::*;

    localparam int DEPTH = 2 ** (TW + AW);

    logic [WGT_W+VAL_W-1:0] mem [DEPTH];
    logic [WGT_W+VAL_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wdata_w, i_wdata_v};
        end
        r_q <= mem[i_raddr];
    end

    assign o_q_w = r_q[WGT_W+VAL_W-1:VAL_W];
    assign o_q_v = r_q[VAL_W-1:0];

endmodule

// File: rtl/core/gap_assignment_evaluator_core.sv
// gap_assignment_evaluator_core: penalty evaluation and greedy repair for assignment
// one request at a time, next one taken from the cycle in which the result shows
// reset (synchronous, active low) clears control, residuals, assignment and totals
// depends on gae_pkg and gae_tab_ram
module gap_assignment_evaluator_core #(
    parameter int MAX_AGENTS = gae_pkg::DEF_MAX_AGENTS,
    parameter int MAX_TASKS  = gae_pkg::DEF_MAX_TASKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config write port
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [gae_pkg::CFG_W-1:0]  i_cfg_data,
    // request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_mode,
    input  logic [5:0]                 i_task_index,
    input  logic [3:0]                 i_agent_index,
    input  logic [gae_pkg::WGT_W-1:0]  i_entry_weight,
    input  logic [gae_pkg::VAL_W-1:0]  i_entry_value,
    input  logic [gae_pkg::WGT_W-1:0]  i_agent_budget,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [40:0]                o_total_value,
    output logic [39:0]                o_total_overload,
    output logic                       o_feasible,
    output logic [3:0]                 o_assigned_agent,
    output logic [6:0]                 o_moves_made
);
    import gae_pkg::*;

    localparam int AW   = $clog2(MAX_AGENTS);
    localparam int TW   = $clog2(MAX_TASKS);
    localparam int AC_W = AW + 1;
    localparam int TC_W = TW + 1;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_FIN_RD  = 19'h00002,
        S_FIN_OUT = 19'h00004,
        S_EB_RD   = 19'h00008,
        S_EB_WR   = 19'h00010,
        S_EJ_RD   = 19'h00020,
        S_EJ_TAB  = 19'h00040,
        S_EJ_WR   = 19'h00080,
        S_EO_RD   = 19'h00100,
        S_EO_ADD  = 19'h00200,
        S_MV_ASG  = 19'h00400,
        S_MV_OLD  = 19'h00800,
        S_MV_SRC  = 19'h01000,
        S_MV_DST  = 19'h02000,
        S_RP_ASG  = 19'h04000,
        S_RP_CUR  = 19'h08000,
        S_RP_LD   = 19'h10000,
        S_RP_CAND = 19'h20000,
        S_RP_CHK  = 19'h40000
    } t_state;

    // config registers
    logic [4:0] r_na_reg;
    logic [6:0] r_nt_reg;
    logic [15:0] na16, nt16;
    logic [AC_W-1:0] na_eff;
    logic [TC_W-1:0] nt_eff;

    // control
    t_state r_state, n_state;
    logic [5:0]       r_in_task;
    logic [TW-1:0]    r_t;
    logic [AW-1:0]    r_a, r_pa;
    logic [AC_W-1:0]  r_i;
    logic [TC_W-1:0]  r_j;
    logic             r_repair;
    logic [6:0]       r_moves;
    logic [VAL_W-1:0] r_cur;
    logic [SUM_W-1:0] r_vold, r_tmp;
    logic [SUM_W-1:0] r_vsum, r_ovl;

    // outputs
    logic        r_ovalid;
    logic [40:0] r_o_value;
    logic [39:0] r_o_ovl;
    logic [3:0]  r_o_agent;
    logic [6:0]  r_o_moves;

    // memories
    logic [AW-1:0]    asg_mem [MAX_TASKS];
    logic             r_asg_vld [MAX_TASKS];
    logic [AW-1:0]    r_asg_q;
    logic [SUM_W-1:0] res_mem [MAX_AGENTS];
    logic             r_res_vld [MAX_AGENTS];
    logic [SUM_W-1:0] r_res_q;
    logic [WGT_W-1:0] bud_mem [MAX_AGENTS];
    logic [WGT_W-1:0] r_bud_q;

    // memory access signals
    logic [TW-1:0]    asg_ra, asg_wa;
    logic [AW-1:0]    asg_wd;
    logic             asg_we;
    logic [AW-1:0]    res_ra, res_wa;
    logic [SUM_W-1:0] res_wd;
    logic             res_we;
    logic [AW-1:0]    bud_ra;
    logic             tab_we;
    logic [TW-1:0]    tab_rt;
    logic [AW-1:0]    tab_ra;
    logic [WGT_W-1:0] tab_w;
    logic [VAL_W-1:0] tab_v;

    logic accept, out_free;
    logic load_ok, agent_ok, set_ok;
    logic [SUM_W-1:0] w40, v40, res_fwd, sum_src, sum_dst;
    logic fits, better, last_i, last_j;

    // effective counts: zero acts as one, clamp to the memory size
    assign na16 = (r_na_reg == 5'd0) ? 16'd1 :
                  ((16'(r_na_reg) > 16'(MAX_AGENTS)) ? 16'(MAX_AGENTS) : 16'(r_na_reg));
    assign nt16 = (r_nt_reg == 7'd0) ? 16'd1 :
                  ((16'(r_nt_reg) > 16'(MAX_TASKS)) ? 16'(MAX_TASKS) : 16'(r_nt_reg));
    assign na_eff = AC_W'(na16);
    assign nt_eff = TC_W'(nt16);

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ovalid || !i_stall;

    assign load_ok  = (16'(i_task_index) < 16'(MAX_TASKS)) &&
                      (16'(i_agent_index) < 16'(MAX_AGENTS));
    assign agent_ok = (16'(i_agent_index) < 16'(MAX_AGENTS));
    assign set_ok   = (16'(i_task_index) < nt16) && (16'(i_agent_index) < na16);

    // table data widened to the sum width
    assign w40 = SUM_W'(tab_w);
    assign v40 = {{(SUM_W-VAL_W){tab_v[VAL_W-1]}}, tab_v};

    // residual of destination, forwarded when source and destination match
    // source update uses the old-cell weight that the table presents in S_MV_SRC
    assign res_fwd = (r_pa == r_a) ? r_tmp : r_res_q;
    assign sum_src = r_res_q + w40;
    assign sum_dst = res_fwd - w40;

    // repair candidate test: weight fits residual, value strictly higher
    assign fits   = !($signed({10'b0, tab_w}) > $signed({r_res_q[SUM_W-1], r_res_q}));
    assign better = $signed(r_cur) < $signed(tab_v);

    assign last_i = ((r_i + AC_W'(1)) == na_eff);
    assign last_j = ((r_j + TC_W'(1)) == nt_eff);

    gae_tab_ram #(
        .AW (AW),
        .TW (TW)
    ) u_tab (
        .i_clk     (i_clk),
        .i_we      (tab_we),
        .i_waddr   ({TW'(i_task_index), AW'(i_agent_index)}),
        .i_wdata_w (i_entry_weight),
        .i_wdata_v (i_entry_value),
        .i_raddr   ({tab_rt, tab_ra}),
        .o_q_w     (tab_w),
        .o_q_v     (tab_v)
    );

    // memory address and write control
    always_comb begin
        tab_we = accept && (i_mode == MODE_LOAD) && load_ok;
        tab_rt = r_t;
        tab_ra = r_a;
        asg_ra = r_t;
        asg_we = 1'b0;
        asg_wa = TW'(i_task_index);
        asg_wd = AW'(i_agent_index);
        res_ra = r_a;
        res_we = 1'b0;
        res_wa = r_a;
        res_wd = sum_dst;
        bud_ra = r_i[AW-1:0];
        case (r_state)
            S_IDLE: begin
                asg_we = accept && (i_mode == MODE_SET) && set_ok;
            end
            S_FIN_RD: begin
                asg_ra = TW'(r_in_task);
            end
            S_FIN_OUT: begin
                // keep the addressed task's agent while the result waits
                asg_ra = TW'(r_in_task);
            end
            S_EB_WR: begin
                res_we = 1'b1;
                res_wa = r_i[AW-1:0];
                res_wd = SUM_W'(r_bud_q);
            end
            S_EJ_RD: begin
                asg_ra = r_j[TW-1:0];
            end
            S_EJ_TAB: begin
                tab_rt = r_j[TW-1:0];
                tab_ra = r_asg_q;
                res_ra = r_asg_q;
            end
            S_EJ_WR: begin
                res_we = 1'b1;
                res_wa = r_a;
                res_wd = r_res_q - w40;
            end
            S_EO_RD: begin
                res_ra = r_i[AW-1:0];
            end
            S_MV_OLD: begin
                tab_ra = r_repair ? r_pa : r_asg_q;
                res_ra = r_repair ? r_pa : r_asg_q;
            end
            S_MV_SRC: begin
                res_we = 1'b1;
                res_wa = r_pa;
                res_wd = sum_src;
            end
            S_MV_DST: begin
                res_we = 1'b1;
                res_wa = r_a;
                res_wd = sum_dst;
                asg_we = 1'b1;
                asg_wa = r_t;
                asg_wd = r_a;
            end
            S_RP_ASG: begin
                asg_ra = r_j[TW-1:0];
            end
            S_RP_CUR: begin
                tab_ra = r_asg_q;
            end
            S_RP_CAND: begin
                tab_ra = r_i[AW-1:0];
                res_ra = r_i[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    // memories with valid bits for the cleared-at-reset stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_asg_vld[k] <= 1'b0;
            end
            for (int k = 0; k < MAX_AGENTS; k++) begin
                r_res_vld[k] <= 1'b0;
            end
        end else begin
            if (asg_we) begin
                r_asg_vld[asg_wa] <= 1'b1;
            end
            if (res_we) begin
                r_res_vld[res_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (asg_we) begin
            asg_mem[asg_wa] <= asg_wd;
        end
        r_asg_q <= r_asg_vld[asg_ra] ? asg_mem[asg_ra] : '0;
        if (res_we) begin
            res_mem[res_wa] <= res_wd;
        end
        r_res_q <= r_res_vld[res_ra] ? res_mem[res_ra] : '0;
        if (accept && (i_mode == MODE_BUDGET) && agent_ok) begin
            bud_mem[AW'(i_agent_index)] <= i_agent_budget;
        end
        r_bud_q <= bud_mem[bud_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_EVAL:     n_state = S_EB_RD;
                        MODE_REASSIGN: n_state = set_ok ? S_MV_ASG : S_FIN_RD;
                        MODE_REPAIR:   n_state = S_RP_ASG;
                        default:       n_state = S_FIN_RD;
                    endcase
                end
            end
            S_FIN_RD:  n_state = S_FIN_OUT;
            S_FIN_OUT: n_state = out_free ? S_IDLE : S_FIN_OUT;
            S_EB_RD:   n_state = S_EB_WR;
            S_EB_WR:   n_state = last_i ? S_EJ_RD : S_EB_RD;
            S_EJ_RD:   n_state = S_EJ_TAB;
            S_EJ_TAB: begin
                if (AC_W'(r_asg_q) >= na_eff) begin
                    n_state = last_j ? S_EO_RD : S_EJ_RD;
                end else begin
                    n_state = S_EJ_WR;
                end
            end
            S_EJ_WR:   n_state = last_j ? S_EO_RD : S_EJ_RD;
            S_EO_RD:   n_state = S_EO_ADD;
            S_EO_ADD:  n_state = last_i ? S_FIN_RD : S_EO_RD;
            S_MV_ASG:  n_state = S_MV_OLD;
            S_MV_OLD:  n_state = S_MV_SRC;
            S_MV_SRC:  n_state = S_MV_DST;
            S_MV_DST: begin
                if (!r_repair) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_state = last_j ? S_FIN_RD : S_RP_ASG;
                end
            end
            S_RP_ASG:  n_state = S_RP_CUR;
            S_RP_CUR:  n_state = S_RP_LD;
            S_RP_LD:   n_state = S_RP_CAND;
            S_RP_CAND: begin
                if (r_i[AW-1:0] == r_pa) begin
                    if (last_i) begin
                        n_state = last_j ? S_FIN_RD : S_RP_ASG;
                    end
                end else begin
                    n_state = S_RP_CHK;
                end
            end
            S_RP_CHK: begin
                if (fits && better) begin
                    n_state = S_MV_OLD;
                end else if (last_i) begin
                    n_state = last_j ? S_FIN_RD : S_RP_ASG;
                end else begin
                    n_state = S_RP_CAND;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_na_reg <= 5'd16;
            r_nt_reg <= 7'd64;
            r_vsum   <= '0;
            r_ovl    <= '0;
            r_ovalid <= 1'b0;
            r_repair <= 1'b0;
            r_moves  <= '0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AGENTS: r_na_reg <= i_cfg_data[4:0];
                    CFG_TASKS:  r_nt_reg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // result register: load a new result or drop one taken downstream
            if ((r_state == S_FIN_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_moves  <= '0;
                        r_repair <= (i_mode == MODE_REPAIR);
                        r_i      <= '0;
                        r_j      <= '0;
                        if (i_mode == MODE_EVAL) begin
                            r_vsum <= '0;
                        end
                    end
                end
                S_EB_WR: begin
                    r_i <= last_i ? '0 : r_i + AC_W'(1);
                end
                S_EJ_TAB: begin
                    if (AC_W'(r_asg_q) >= na_eff) begin
                        r_j <= r_j + TC_W'(1);
                        if (last_j) begin
                            r_ovl <= '0;
                        end
                    end
                end
                S_EJ_WR: begin
                    r_vsum <= r_vsum + v40;
                    r_j    <= r_j + TC_W'(1);
                    if (last_j) begin
                        r_ovl <= '0;
                    end
                end
                S_EO_ADD: begin
                    // overload adds the magnitude of a negative residual
                    if (r_res_q[SUM_W-1]) begin
                        r_ovl <= r_ovl - r_res_q;
                    end
                    r_i <= r_i + AC_W'(1);
                end
                S_MV_SRC: begin
                    if (r_res_q[SUM_W-1]) begin
                        r_ovl <= sum_src[SUM_W-1] ? (r_ovl - w40) : (r_ovl + r_res_q);
                    end
                end
                S_MV_DST: begin
                    r_vsum <= r_vsum + v40 - r_vold;
                    if (sum_dst[SUM_W-1]) begin
                        r_ovl <= res_fwd[SUM_W-1] ? (r_ovl + w40) : (r_ovl - sum_dst);
                    end
                    if (r_repair) begin
                        r_moves <= r_moves + 7'd1;
                        r_j     <= r_j + TC_W'(1);
                    end
                end
                S_RP_LD: begin
                    r_i <= '0;
                end
                S_RP_CAND: begin
                    if (r_i[AW-1:0] == r_pa) begin
                        r_i <= r_i + AC_W'(1);
                        if (last_i) begin
                            r_j <= r_j + TC_W'(1);
                        end
                    end
                end
                S_RP_CHK: begin
                    if (!(fits && better)) begin
                        r_i <= r_i + AC_W'(1);
                        if (last_i) begin
                            r_j <= r_j + TC_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_task <= i_task_index;
            r_t       <= TW'(i_task_index);
            r_a       <= AW'(i_agent_index);
        end
        case (r_state)
            S_EJ_TAB: r_a <= r_asg_q;
            S_MV_OLD: begin
                if (!r_repair) begin
                    r_pa <= r_asg_q;
                end
            end
            S_MV_SRC: begin
                r_vold <= v40;
                r_tmp  <= sum_src;
            end
            S_RP_ASG: r_t   <= r_j[TW-1:0];
            S_RP_CUR: r_pa  <= r_asg_q;
            S_RP_LD:  r_cur <= tab_v;
            S_RP_CHK: r_a   <= r_i[AW-1:0];
            S_FIN_OUT: begin
                if (out_free) begin
                    r_o_value <= {r_vsum[SUM_W-1], r_vsum};
                    r_o_ovl   <= r_ovl;
                    r_o_moves <= r_moves;
                    r_o_agent <= (16'(r_in_task) < 16'(MAX_TASKS)) ? 4'(r_asg_q) : 4'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_total_value    = r_o_value;
    assign o_total_overload = r_o_ovl;
    assign o_feasible       = (r_o_ovl == 40'd0);
    assign o_assigned_agent = r_o_agent;
    assign o_moves_made     = r_o_moves;

endmodule
